/* design/cps_pkg.sv */
// ----------------------------------------------------------------------------
// cps_pkg: closest point on segment shared types
// Word types, divider step state and sideband carried along the pipeline.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned MagW  = 65;
  localparam int unsigned QuoW  = 32;

  typedef struct packed {
    logic              func;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } cps_in_t;

  typedef struct packed {
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] param_t;
    logic               degenerate;
    logic               saturated;
  } cps_out_t;

  typedef struct packed {
    logic [MagW-1:0] rem;
    logic [MagW-1:0] den;
    logic [QuoW-1:0] nlo;
    logic [QuoW-1:0] quo;
    logic            ovf;
    logic            ge1;
  } cps_div_t;

  typedef struct packed {
    logic             func;
    logic             degen;
    logic             numneg;
    logic [DataW-1:0] ax;
    logic [DataW-1:0] ay;
    logic [DataW-1:0] dxm;
    logic [DataW-1:0] dym;
    logic             dxn;
    logic             dyn;
  } cps_side_t;

endpackage

/* design/cps_front.sv */
// ----------------------------------------------------------------------------
// cps_front: vector and dot product stages
// Forms AB and AP, the dot products and the divider start state.
// ----------------------------------------------------------------------------
module cps_front import cps_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  cps_in_t   data_i,
  output logic      valid_o,
  output cps_div_t  div_o,
  output cps_side_t side_o
);

  localparam int unsigned NumW = MagW + FRAC_BITS;

  logic [2:0] vld_q;

  logic [DataW:0]   dx, dy, ex, ey;
  logic [DataW-1:0] exm_d, eym_d;
  logic             exn_d, eyn_d;
  cps_side_t        s1_side_d;

  logic [DataW-1:0] s1_exm_q, s1_eym_q;
  logic             s1_exn_q, s1_eyn_q;
  cps_side_t        s1_side_q;

  logic [2*DataW-1:0] s2_pxx_q, s2_pyy_q, s2_pex_q, s2_pey_q;
  logic               s2_sx_q, s2_sy_q;
  cps_side_t          s2_side_q;

  logic [MagW:0]   tx, ty;
  logic [MagW-1:0] s3_ab2_q;
  logic [MagW:0]   s3_num_q;
  cps_side_t       s3_side_q;

  logic [MagW:0]   negnum;
  logic [MagW-1:0] mag;
  logic [NumW-1:0] nbig;
  logic [MagW-1:0] nhi;
  cps_div_t        div_d;
  cps_side_t       side_d;

  always_comb begin
    dx    = {data_i.bx[31], data_i.bx} - {data_i.ax[31], data_i.ax};
    dy    = {data_i.by[31], data_i.by} - {data_i.ay[31], data_i.ay};
    ex    = {data_i.px[31], data_i.px} - {data_i.ax[31], data_i.ax};
    ey    = {data_i.py[31], data_i.py} - {data_i.ay[31], data_i.ay};
    exn_d = ex[DataW];
    eyn_d = ey[DataW];
    exm_d = ex[DataW] ? DataW'(~ex + 1'b1) : ex[DataW-1:0];
    eym_d = ey[DataW] ? DataW'(~ey + 1'b1) : ey[DataW-1:0];
    s1_side_d.func   = data_i.func;
    s1_side_d.degen  = (data_i.ax == data_i.bx) && (data_i.ay == data_i.by);
    s1_side_d.numneg = 1'b0;
    s1_side_d.ax     = data_i.ax;
    s1_side_d.ay     = data_i.ay;
    s1_side_d.dxn    = dx[DataW];
    s1_side_d.dyn    = dy[DataW];
    s1_side_d.dxm    = dx[DataW] ? DataW'(~dx + 1'b1) : dx[DataW-1:0];
    s1_side_d.dym    = dy[DataW] ? DataW'(~dy + 1'b1) : dy[DataW-1:0];
  end

  always_comb begin
    tx = s2_sx_q ? (MagW+1)'(-{2'b00, s2_pex_q}) : {2'b00, s2_pex_q};
    ty = s2_sy_q ? (MagW+1)'(-{2'b00, s2_pey_q}) : {2'b00, s2_pey_q};
  end

  always_comb begin
    negnum = ~s3_num_q + 1'b1;
    mag    = s3_num_q[MagW] ? negnum[MagW-1:0] : s3_num_q[MagW-1:0];
    nbig   = NumW'(mag) << FRAC_BITS;
    nhi    = MagW'(nbig[NumW-1:QuoW]);
    div_d.rem = nhi;
    div_d.den = s3_ab2_q;
    div_d.nlo = nbig[QuoW-1:0];
    div_d.quo = '0;
    div_d.ovf = nhi >= s3_ab2_q;
    div_d.ge1 = mag >= s3_ab2_q;
    side_d        = s3_side_q;
    side_d.numneg = s3_num_q[MagW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[1:0], valid_i};
      valid_o <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_exm_q  <= exm_d;
      s1_eym_q  <= eym_d;
      s1_exn_q  <= exn_d;
      s1_eyn_q  <= eyn_d;
      s1_side_q <= s1_side_d;
      s2_pxx_q  <= s1_side_q.dxm * s1_side_q.dxm;
      s2_pyy_q  <= s1_side_q.dym * s1_side_q.dym;
      s2_pex_q  <= s1_exm_q * s1_side_q.dxm;
      s2_pey_q  <= s1_eym_q * s1_side_q.dym;
      s2_sx_q   <= s1_exn_q ^ s1_side_q.dxn;
      s2_sy_q   <= s1_eyn_q ^ s1_side_q.dyn;
      s2_side_q <= s1_side_q;
      s3_ab2_q  <= {1'b0, s2_pxx_q} + {1'b0, s2_pyy_q};
      s3_num_q  <= tx + ty;
      s3_side_q <= s2_side_q;
      div_o     <= div_d;
      side_o    <= side_d;
    end
  end

endmodule

/* design/cps_div_step.sv */
// ----------------------------------------------------------------------------
// cps_div_step: one restoring divider stage
// Brings down one numerator bit and produces one quotient bit.
// ----------------------------------------------------------------------------
module cps_div_step import cps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  cps_div_t  div_i,
  input  cps_side_t side_i,
  output logic      valid_o,
  output cps_div_t  div_o,
  output cps_side_t side_o
);

  logic [MagW:0] part;
  logic [MagW:0] diff;
  logic          take;
  cps_div_t      div_d;

  always_comb begin
    part  = {div_i.rem, div_i.nlo[QuoW-1]};
    diff  = part - {1'b0, div_i.den};
    take  = part >= {1'b0, div_i.den};
    div_d      = div_i;
    div_d.rem  = take ? diff[MagW-1:0] : part[MagW-1:0];
    div_d.nlo  = {div_i.nlo[QuoW-2:0], 1'b0};
    div_d.quo  = {div_i.quo[QuoW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_o  <= div_d;
      side_o <= side_i;
    end
  end

endmodule

/* design/cps_back.sv */
// ----------------------------------------------------------------------------
// cps_back: parameter select and point reconstruction
// Clamps or saturates t, forms A + AB * t and saturates the coordinates.
// ----------------------------------------------------------------------------
module cps_back import cps_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  cps_div_t  div_i,
  input  cps_side_t side_i,
  output logic      valid_o,
  output cps_out_t  data_o
);

  localparam logic [DataW-1:0] TMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] TMin = {1'b1, {(DataW-1){1'b0}}};

  logic [1:0] vld_q;

  logic [DataW-1:0] t_d, tm_d;
  logic             tn_d, sat_d;

  logic [DataW-1:0] s1_t_q, s1_tm_q;
  logic             s1_tn_q, s1_sat_q;
  cps_side_t        s1_side_q;

  logic [2*DataW-1:0] s2_px_q, s2_py_q;
  logic               s2_xn_q, s2_yn_q;
  logic [DataW-1:0]   s2_t_q;
  logic               s2_sat_q;
  cps_side_t          s2_side_q;

  logic [2*DataW+1:0] mx, my, ax_w, ay_w, sx, sy;
  logic               ovx, ovy;
  cps_out_t           out_d;

  always_comb begin
    t_d   = '0;
    tm_d  = '0;
    tn_d  = 1'b0;
    sat_d = 1'b0;
    if (side_i.degen) begin
      t_d = '0;
    end else if (side_i.func) begin
      if (side_i.numneg) begin
        t_d = '0;
      end else if (div_i.ge1) begin
        t_d = DataW'(1) << FRAC_BITS;
      end else begin
        t_d = div_i.quo;
      end
      tm_d = t_d;
    end else if (side_i.numneg) begin
      if (div_i.ovf || div_i.quo > TMin) begin
        t_d   = TMin;
        tm_d  = TMin;
        sat_d = 1'b1;
      end else begin
        t_d  = ~div_i.quo + 1'b1;
        tm_d = div_i.quo;
      end
      tn_d = (tm_d != '0);
    end else begin
      if (div_i.ovf || div_i.quo[DataW-1]) begin
        t_d   = TMax;
        sat_d = 1'b1;
      end else begin
        t_d = div_i.quo;
      end
      tm_d = t_d;
    end
  end

  always_comb begin
    mx   = {2'b00, s2_px_q >> FRAC_BITS};
    my   = {2'b00, s2_py_q >> FRAC_BITS};
    ax_w = {{(DataW+2){s2_side_q.ax[DataW-1]}}, s2_side_q.ax};
    ay_w = {{(DataW+2){s2_side_q.ay[DataW-1]}}, s2_side_q.ay};
    sx   = s2_xn_q ? ax_w - mx : ax_w + mx;
    sy   = s2_yn_q ? ay_w - my : ay_w + my;
    ovx  = (sx[2*DataW+1:DataW-1] != '0) && (sx[2*DataW+1:DataW-1] != '1);
    ovy  = (sy[2*DataW+1:DataW-1] != '0) && (sy[2*DataW+1:DataW-1] != '1);
    out_d.qx         = ovx ? (sx[2*DataW+1] ? TMin : TMax) : sx[DataW-1:0];
    out_d.qy         = ovy ? (sy[2*DataW+1] ? TMin : TMax) : sy[DataW-1:0];
    out_d.param_t    = s2_t_q;
    out_d.degenerate = s2_side_q.degen;
    out_d.saturated  = s2_sat_q || ovx || ovy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[0], valid_i};
      valid_o <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_t_q    <= t_d;
      s1_tm_q   <= tm_d;
      s1_tn_q   <= tn_d;
      s1_sat_q  <= sat_d;
      s1_side_q <= side_i;
      s2_px_q   <= s1_side_q.dxm * s1_tm_q;
      s2_py_q   <= s1_side_q.dym * s1_tm_q;
      s2_xn_q   <= s1_side_q.dxn ^ s1_tn_q;
      s2_yn_q   <= s1_side_q.dyn ^ s1_tn_q;
      s2_t_q    <= s1_t_q;
      s2_sat_q  <= s1_sat_q;
      s2_side_q <= s1_side_q;
      data_o    <= out_d;
    end
  end

endmodule

/* design/closest_point_on_segment.sv */
// ----------------------------------------------------------------------------
// closest_point_on_segment: projection of a point onto a line or segment
// Pipeline: 4 front, 32 divider and 3 back stages, input to output word.
// Throughput: one word per cycle unless stalled; the 32-stage restoring
// divider takes one quotient bit per stage. The whole pipeline holds while
// the output word is not taken. Reset clears all valid bits at once.
// ----------------------------------------------------------------------------
module closest_point_on_segment import cps_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cps_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cps_out_t out_data_o
);

  logic      en;
  logic      vld   [QuoW+1];
  cps_div_t  div_w [QuoW+1];
  cps_side_t side_w[QuoW+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  cps_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .data_i (in_data_i),
    .valid_o(vld[0]),
    .div_o  (div_w[0]),
    .side_o (side_w[0])
  );

  for (genvar i = 0; i < QuoW; i++) begin : g_div
    cps_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(vld[i]),
      .div_i  (div_w[i]),
      .side_i (side_w[i]),
      .valid_o(vld[i+1]),
      .div_o  (div_w[i+1]),
      .side_o (side_w[i+1])
    );
  end

  cps_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(vld[QuoW]),
    .div_i  (div_w[QuoW]),
    .side_i (side_w[QuoW]),
    .valid_o(out_valid_o),
    .data_o (out_data_o)
  );

  a_degen_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      !out_data_o.saturated && out_data_o.param_t == '0)
    else $error("degenerate word carries t or saturation");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.param_t == 32'sh7fffffff || out_data_o.param_t == 32'sh80000000 ||
      out_data_o.qx == 32'sh7fffffff || out_data_o.qx == 32'sh80000000 ||
      out_data_o.qy == 32'sh7fffffff || out_data_o.qy == 32'sh80000000)
    else $error("saturation flag without a value at a limit");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld[QuoW/2]) && $stable(div_w[QuoW/2]))
    else $error("divider stage moved during stall");

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: closest point on segment
// Directed and random words go through a valid/ready driver. An inline
// projection predictor builds the expected words, and the monitor checks
// each output word field by field. The run uses random stalls on both sides
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import cps_pkg::*;

  localparam int unsigned NumRandom = 780;
  localparam int unsigned Frac      = 16;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  cps_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  cps_out_t out_data;

  cps_in_t  pending_q[$];
  cps_out_t projection_q[$];
  int       accepted;
  int       errors = 0;
  int       hold_cycles;
  bit       hold_done;

  closest_point_on_segment u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint offset_coord(longint a, longint d, longint t, inout bit sat);
    logic [127:0] m;
    longint       s;
    m = (128'(d < 0 ? -d : d) * 128'(t < 0 ? -t : t)) >> Frac;
    if (m > (128'd1 << 33)) m = 128'd1 << 33;
    s = ((d < 0) != (t < 0)) ? a - longint'(m) : a + longint'(m);
    if (s > 64'sd2147483647) begin
      s = 64'sd2147483647;
      sat = 1'b1;
    end
    if (s < -64'sd2147483648) begin
      s = -64'sd2147483648;
      sat = 1'b1;
    end
    return s;
  endfunction

  function automatic cps_out_t project(cps_in_t w);
    cps_out_t          r;
    logic signed [127:0] dx, dy, ex, ey, ab2, num;
    logic [127:0]      mag, quo;
    longint            t;
    bit                sat;
    dx  = 128'(longint'(w.bx) - longint'(w.ax));
    dy  = 128'(longint'(w.by) - longint'(w.ay));
    ex  = 128'(longint'(w.px) - longint'(w.ax));
    ey  = 128'(longint'(w.py) - longint'(w.ay));
    sat = 1'b0;
    r   = '0;
    if (dx == 0 && dy == 0) begin
      r.qx         = w.ax;
      r.qy         = w.ay;
      r.degenerate = 1'b1;
      return r;
    end
    ab2 = dx * dx + dy * dy;
    num = ex * dx + ey * dy;
    mag = num < 0 ? -num : num;
    quo = (mag << Frac) / ab2;
    if (w.func) begin
      if (num < 0) t = 0;
      else if (mag >= ab2) t = longint'(1) << Frac;
      else t = longint'(quo);
    end else if (num < 0) begin
      if (quo > 128'h8000_0000) begin
        t   = -64'sd2147483648;
        sat = 1'b1;
      end else begin
        t = -longint'(quo);
      end
    end else begin
      if (quo > 128'h7FFF_FFFF) begin
        t   = 64'sd2147483647;
        sat = 1'b1;
      end else begin
        t = longint'(quo);
      end
    end
    r.qx        = 32'(offset_coord(w.ax, longint'(dx), t, sat));
    r.qy        = 32'(offset_coord(w.ay, longint'(dy), t, sat));
    r.param_t   = 32'(t);
    r.saturated = sat;
    return r;
  endfunction

  function automatic cps_in_t mk(bit f, int ax, int ay, int bx, int by, int px, int py);
    cps_in_t w;
    w.func = f;
    w.ax = ax;
    w.ay = ay;
    w.bx = bx;
    w.by = by;
    w.px = px;
    w.py = py;
    return w;
  endfunction

  function automatic int small_val();
    return int'($urandom_range(0, 20 << Frac)) - (10 << Frac);
  endfunction

  function automatic int send_idle_pct();
    if (accepted < 270) return 29;
    if (accepted < 540) return 55;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted < 270) return 55;
    if (accepted < 540) return 29;
    return 0;
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      accepted <= 0;
    end else begin
      if (in_valid && in_ready) begin
        projection_q.push_back(project(in_data));
        accepted <= accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin
    cps_out_t e;
    if (!rst_n) begin
      out_ready   <= 1'b0;
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (projection_q.size() == 0) begin
          $error("unexpected output word");
          errors++;
        end else begin
          e = projection_q.pop_front();
          if (out_data.qx !== e.qx) begin
            $error("qx expected %h got %h", e.qx, out_data.qx);
            errors++;
          end
          if (out_data.qy !== e.qy) begin
            $error("qy expected %h got %h", e.qy, out_data.qy);
            errors++;
          end
          if (out_data.param_t !== e.param_t) begin
            $error("param_t expected %h got %h", e.param_t, out_data.param_t);
            errors++;
          end
          if (out_data.degenerate !== e.degenerate) begin
            $error("degenerate expected %b got %b", e.degenerate, out_data.degenerate);
            errors++;
          end
          if (out_data.saturated !== e.saturated) begin
            $error("saturated expected %b got %b", e.saturated, out_data.saturated);
            errors++;
          end
        end
      end
      if (!hold_done && accepted >= 560) begin
        hold_done   <= 1'b1;
        hold_cycles <= 200;
        out_ready   <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready   <= 1'b0;
      end else begin
        out_ready <= $urandom_range(0, 99) >= recv_idle_pct();
      end
    end
  end

  initial begin
    cps_in_t w;
    int      k;
    int      ax, ay;
    rst_n  = 1'b0;
    for (int f = 0; f < 2; f++) begin
      pending_q.push_back(mk(1'(f), 0, 0, 1 << Frac, 0, 1 << 15, 5 << Frac));
      pending_q.push_back(mk(1'(f), 0, 0, 1 << Frac, 0, -(3 << Frac), 1));
      pending_q.push_back(mk(1'(f), 0, 0, 1 << Frac, 1 << Frac, 4 << Frac, 4 << Frac));
      pending_q.push_back(mk(1'(f), 5, 7, 5, 7, 100, -100));
      pending_q.push_back(mk(1'(f), 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF, 0, 0));
      pending_q.push_back(mk(1'(f), 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 0, 0));
      pending_q.push_back(mk(1'(f), 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
      pending_q.push_back(mk(1'(f), 0, 0, 1, 0, 32'h7FFF_FFFF, 0));
      pending_q.push_back(mk(1'(f), 0, 0, 1, 0, 32'h8000_0000, 0));
      pending_q.push_back(mk(1'(f), 32'h7FFF_0000, 0, 32'h7FFF_FFFF, 1, 32'h8000_0000,
                             32'h7FFF_FFFF));
      pending_q.push_back(mk(1'(f), -1, -1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF));
      pending_q.push_back(mk(1'(f), 0, 0, 4 << Frac, 0, 4 << Frac, 9));
    end
    for (int i = 0; i < NumRandom; i++) begin
      k  = $urandom_range(0, 9);
      ax = small_val();
      ay = small_val();
      w  = mk(1'($urandom_range(0, 1)), ax, ay, small_val(), small_val(), small_val(),
              small_val());
      if (k < 2) begin
        w = mk(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom);
      end else if (k == 2) begin
        w.bx = ax + int'($urandom_range(0, 6)) - 3;
        w.by = ay + int'($urandom_range(0, 6)) - 3;
        w.px = $urandom;
        w.py = $urandom;
      end else if (k == 3) begin
        w.bx = ax;
        w.by = ay;
      end
      pending_q.push_back(w);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    forever begin
      @(posedge clk);
      if (pending_q.size() == 0 && !in_valid && projection_q.size() == 0) break;
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && projection_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
